// File: design/dwpid_pkg.sv
// ----------------------------------------------------------------------------
// dwpid_pkg: shared types and constants
// Constants, item kinds, register indexes and the controller/datapath
// command and status structs for the two-wheel speed controller.
// ----------------------------------------------------------------------------
package dwpid_pkg;

    localparam int TICK_MS_DEF        = 10;
    localparam int MAX_WIDTH_DEF      = 1000;
    localparam int RPS_LIMIT_DEF      = 10;
    localparam int BALANCE_PERIOD_DEF = 80;
    localparam int CLEAR_PERIOD_DEF   = 200;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    localparam logic [2:0] REG_KP   = 3'd0;
    localparam logic [2:0] REG_KI   = 3'd1;
    localparam logic [2:0] REG_KD   = 3'd2;
    localparam logic [2:0] REG_LCPR = 3'd3;
    localparam logic [2:0] REG_LOFS = 3'd4;
    localparam logic [2:0] REG_RCPR = 3'd5;
    localparam logic [2:0] REG_ROFS = 3'd6;

    localparam int INTEG_MAX = 6553600;

    // datapath operation codes
    localparam logic [2:0] OP_LOAD  = 3'd0; // capture item
    localparam logic [2:0] OP_PID   = 3'd1; // integral/derivative for wheel
    localparam logic [2:0] OP_MUL_P = 3'd2;
    localparam logic [2:0] OP_MUL_I = 3'd3;
    localparam logic [2:0] OP_MUL_D = 3'd4;
    localparam logic [2:0] OP_MAP   = 3'd5; // width map multiply
    localparam logic [2:0] OP_WID   = 3'd6; // width from product
    localparam logic [2:0] OP_FIN   = 3'd7; // balance, clear, commit

    typedef struct packed {
        logic       en;
        logic [2:0] op;
        logic       wheel;     // 0 left, 1 right
        logic       open_loop; // start item: map the setpoint
        logic       do_bal;
        logic       do_clr;
    } t_cmd;

    typedef struct packed {
        logic running;
        logic bal_hit;
        logic clr_hit;
    } t_stat;

endpackage

// File: design/dwpid_ctrl.sv
// ----------------------------------------------------------------------------
// dwpid_ctrl: controller sequencer
// Steps the datapath through one item and runs the output handshake.
// ----------------------------------------------------------------------------
module dwpid_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic [1:0]       i_kind,
    input  dwpid_pkg::t_stat i_stat,
    input  logic             i_out_ready,
    output logic             o_busy,
    output logic             o_out_valid,
    output dwpid_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PID  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_MAP  = 3'd3;
    localparam logic [2:0] S_WID  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_sub, n_sub;
    logic       r_wheel, n_wheel;
    logic       r_open, n_open;

    always_comb begin
        n_state = r_state;
        n_sub   = r_sub;
        n_wheel = r_wheel;
        n_open  = r_open;
        o_cmd   = '0;
        o_cmd.wheel     = r_wheel;
        o_cmd.open_loop = r_open;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.en = 1'b1;
                    o_cmd.op = dwpid_pkg::OP_LOAD;
                    n_wheel  = 1'b0;
                    n_sub    = 2'd0;
                    if (i_kind == dwpid_pkg::KIND_START) begin
                        n_open  = 1'b1;
                        n_state = S_MAP;
                    end else if (i_kind == dwpid_pkg::KIND_TICK && i_stat.running) begin
                        n_open  = 1'b0;
                        n_state = S_PID;
                    end
                end
            end
            S_PID: begin
                o_cmd.en = 1'b1;
                o_cmd.op = dwpid_pkg::OP_PID;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.en = 1'b1;
                case (r_sub)
                    2'd0:    o_cmd.op = dwpid_pkg::OP_MUL_P;
                    2'd1:    o_cmd.op = dwpid_pkg::OP_MUL_I;
                    default: o_cmd.op = dwpid_pkg::OP_MUL_D;
                endcase
                if (r_sub == 2'd2) begin
                    n_sub   = 2'd0;
                    n_state = S_MAP;
                end else begin
                    n_sub = r_sub + 2'd1;
                end
            end
            S_MAP: begin
                o_cmd.en = 1'b1;
                o_cmd.op = dwpid_pkg::OP_MAP;
                n_state  = S_WID;
            end
            S_WID: begin
                o_cmd.en = 1'b1;
                o_cmd.op = dwpid_pkg::OP_WID;
                if (!r_wheel) begin
                    n_wheel = 1'b1;
                    n_state = r_open ? S_MAP : S_PID;
                end else begin
                    n_state = r_open ? S_OUT : S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.en     = 1'b1;
                o_cmd.op     = dwpid_pkg::OP_FIN;
                o_cmd.do_bal = i_stat.bal_hit;
                o_cmd.do_clr = i_stat.clr_hit;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sub   <= 2'd0;
            r_wheel <= 1'b0;
            r_open  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_wheel <= n_wheel;
            r_open  <= n_open;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

// File: design/dwpid_dp.sv
// ----------------------------------------------------------------------------
// dwpid_dp: shared-multiplier datapath
// Holds wheel state and registers, one multiplier reused for the gain and map products.
// ----------------------------------------------------------------------------
module dwpid_dp #(
    parameter int TICK_MS        = dwpid_pkg::TICK_MS_DEF,
    parameter int MAX_WIDTH      = dwpid_pkg::MAX_WIDTH_DEF,
    parameter int RPS_LIMIT      = dwpid_pkg::RPS_LIMIT_DEF,
    parameter int BALANCE_PERIOD = dwpid_pkg::BALANCE_PERIOD_DEF,
    parameter int CLEAR_PERIOD   = dwpid_pkg::CLEAR_PERIOD_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_fire,
    input  logic [2:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic [1:0]       i_kind,
    input  logic [15:0]      i_lsamp,
    input  logic [15:0]      i_rsamp,
    input  logic [15:0]      i_ltgt,
    input  logic [15:0]      i_rtgt,
    input  logic             i_lfwd,
    input  logic             i_rfwd,
    input  dwpid_pkg::t_cmd  i_cmd,
    output dwpid_pkg::t_stat o_stat,
    output logic [9:0]       o_lwidth,
    output logic [9:0]       o_rwidth,
    output logic             o_lfwd,
    output logic             o_rfwd
);

    localparam int          LIM   = RPS_LIMIT * 1024;
    localparam int          DMUL  = 1000 / TICK_MS;
    localparam int          DREM  = 1000 % TICK_MS;
    localparam logic [16:0] LIM17 = 17'(LIM);
    // ceil(2^33/125): exact quotient while |err|*8*TICK_MS stays below 2^26
    localparam longint      IREC  = ((64'sd1 <<< 33) + 64'sd124) / 64'sd125;
    localparam longint      IK    = 64'(8 * TICK_MS) * IREC;
    // ceil(2^31/TICK_MS): exact quotient while |diff|*DREM stays below 2^24
    localparam longint      DREC  = ((64'sd1 <<< 31) + 64'(TICK_MS) - 64'sd1) / 64'(TICK_MS);
    localparam longint      DK    = 64'(DREM) * DREC;

    // configuration
    logic [15:0] r_kp, r_ki, r_kd, r_lcpr, r_rcpr;
    logic signed [15:0] r_lofs, r_rofs;

    // wheel state
    logic [16:0]        r_sp   [2];
    logic               r_dir  [2];
    logic signed [23:0] r_int  [2];
    logic signed [16:0] r_perr [2];
    logic               r_running;
    logic [6:0]         r_bal;
    logic [7:0]         r_clr;

    // per-item work registers
    logic signed [15:0] r_samp [2];
    logic signed [16:0] r_err;
    logic signed [27:0] r_der;
    logic signed [31:0] r_out;
    logic signed [47:0] r_prod;
    logic [9:0]         r_w [2];

    logic               w;
    logic signed [16:0] err_c;
    logic [16:0]        eabs_c;
    logic [52:0]        iprod_c;
    logic [19:0]        iq_c;
    logic signed [35:0] inc_c;
    logic signed [25:0] acc_c;
    logic signed [23:0] accs_c;
    logic signed [17:0] dd_c;
    logic [16:0]        dabs_c;
    logic [48:0]        dprod_c;
    logic [17:0]        dq_c;
    logic signed [27:0] der_c;
    logic signed [16:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [48:0] mul_p;
    logic signed [31:0] out_c;
    logic signed [31:0] omax_c;
    logic signed [32:0] rel_c;
    logic [29:0]        wq_c;
    logic [9:0]         wid_c;
    logic signed [16:0] diff_c, adj_c;
    logic [31:0]        t10_c, t20_c;
    logic signed [18:0] lsp_c, rsp_c;

    assign w = i_cmd.wheel;

    function automatic logic [16:0] clamp_sp(input logic signed [18:0] v);
        if (v < 0) return '0;
        if (v > 19'(LIM)) return LIM17;
        return v[16:0];
    endfunction

    always_comb begin
        err_c  = $signed(r_sp[w]) - 17'(r_samp[w]);
        // integral step err*64*TICK_MS/1000, truncated toward zero
        eabs_c  = err_c[16] ? 17'(-err_c) : 17'(err_c);
        iprod_c = 53'(eabs_c) * 53'(IK);
        iq_c    = iprod_c[52:33];
        inc_c   = err_c[16] ? -36'($signed({1'b0, iq_c})) : 36'($signed({1'b0, iq_c}));
        acc_c  = 26'(r_int[w]) + 26'(inc_c);
        if (acc_c > 26'(dwpid_pkg::INTEG_MAX))       accs_c = 24'(dwpid_pkg::INTEG_MAX);
        else if (acc_c < -26'(dwpid_pkg::INTEG_MAX)) accs_c = -24'(dwpid_pkg::INTEG_MAX);
        else                                         accs_c = acc_c[23:0];
        // derivative (err-prev)*1000/TICK_MS, truncated toward zero
        dd_c    = 18'(err_c) - 18'(r_perr[w]);
        dabs_c  = dd_c[17] ? 17'(-dd_c) : 17'(dd_c);
        dprod_c = 49'(dabs_c) * 49'(DK);
        dq_c    = dprod_c[48:31];
        der_c   = 28'(dd_c) * 28'(DMUL)
                + (dd_c[17] ? -28'($signed({1'b0, dq_c})) : 28'($signed({1'b0, dq_c})));
        out_c  = r_out + 32'(r_prod >>> 12);
        omax_c = (out_c > 32'(LIM)) ? 32'(LIM) : out_c;
        mul_a  = '0;
        mul_b  = '0;
        rel_c  = '0;
        case (i_cmd.op)
            dwpid_pkg::OP_MUL_P: begin
                mul_a = $signed({1'b0, r_kp});
                mul_b = 32'(r_err);
            end
            dwpid_pkg::OP_MUL_I: begin
                mul_a = $signed({1'b0, r_ki});
                mul_b = 32'(r_int[w]);
            end
            dwpid_pkg::OP_MUL_D: begin
                mul_a = $signed({1'b0, r_kd});
                mul_b = 32'(r_der);
            end
            dwpid_pkg::OP_MAP: begin
                rel_c = (i_cmd.open_loop ? 33'($signed(r_sp[w])) : 33'(omax_c))
                      - 33'(w ? r_rofs : r_lofs);
                mul_a = $signed({1'b0, (w ? r_rcpr : r_lcpr)});
                mul_b = 32'(rel_c);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
        wq_c  = r_prod[47:18];
        if (r_prod < 0)                 wid_c = 10'd1;
        else if (wq_c > 30'(MAX_WIDTH)) wid_c = 10'(MAX_WIDTH);
        else                            wid_c = wq_c[9:0];
        diff_c = 17'(r_samp[0]) - 17'(r_samp[1]);
        // d/10 and d/20 by reciprocal, exact for the small tiers
        t10_c  = 32'(diff_c[15:0]) * 32'd6554;
        t20_c  = 32'(diff_c[15:0]) * 32'd3277;
        if (diff_c > 17'sd1024)     adj_c = diff_c >>> 1;
        else if (diff_c > 17'sd512) adj_c = $signed({1'b0, t10_c[31:16]});
        else if (diff_c > 17'sd102) adj_c = $signed({1'b0, t20_c[31:16]});
        else                        adj_c = '0;
        lsp_c = 19'($signed(r_sp[0])) - 19'(adj_c);
        rsp_c = 19'($signed(r_sp[1])) + 19'(adj_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= 16'd3277; r_ki <= 16'd41; r_kd <= 16'd0;
            r_lcpr <= 16'd18688; r_lofs <= -16'sd429;
            r_rcpr <= 16'd20204; r_rofs <= 16'sd155;
            r_sp[0] <= '0; r_sp[1] <= '0;
            r_dir[0] <= 1'b1; r_dir[1] <= 1'b1;
            r_int[0] <= '0; r_int[1] <= '0;
            r_perr[0] <= '0; r_perr[1] <= '0;
            r_running <= 1'b0;
            r_bal <= '0;
            r_clr <= '0;
        end else begin
            if (i_cfg_fire) begin
                case (i_cfg_index)
                    dwpid_pkg::REG_KP:   r_kp   <= i_cfg_data;
                    dwpid_pkg::REG_KI:   r_ki   <= i_cfg_data;
                    dwpid_pkg::REG_KD:   r_kd   <= i_cfg_data;
                    dwpid_pkg::REG_LCPR: r_lcpr <= i_cfg_data;
                    dwpid_pkg::REG_LOFS: r_lofs <= i_cfg_data;
                    dwpid_pkg::REG_RCPR: r_rcpr <= i_cfg_data;
                    dwpid_pkg::REG_ROFS: r_rofs <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.en && i_cmd.op == dwpid_pkg::OP_LOAD) begin
                case (i_kind)
                    dwpid_pkg::KIND_MOVE: begin
                        r_sp[0]  <= clamp_sp(19'($signed(i_ltgt)));
                        r_sp[1]  <= clamp_sp(19'($signed(i_rtgt)));
                        r_dir[0] <= i_lfwd;
                        r_dir[1] <= i_rfwd;
                    end
                    dwpid_pkg::KIND_STOP: begin
                        r_running <= 1'b0;
                        r_clr     <= '0;
                    end
                    dwpid_pkg::KIND_START: r_running <= 1'b1;
                    default: ;
                endcase
            end
            if (i_cmd.en && i_cmd.op == dwpid_pkg::OP_PID) begin
                r_int[w]  <= accs_c;
                r_perr[w] <= err_c;
            end
            if (i_cmd.en && i_cmd.op == dwpid_pkg::OP_FIN) begin
                r_bal <= i_cmd.do_bal ? '0 : r_bal + 7'd1;
                r_clr <= i_cmd.do_clr ? '0 : r_clr + 8'd1;
                if (i_cmd.do_bal) begin
                    r_sp[0] <= clamp_sp(lsp_c);
                    r_sp[1] <= clamp_sp(rsp_c);
                end
                if (i_cmd.do_clr) begin
                    r_int[0] <= '0; r_int[1] <= '0;
                    r_perr[0] <= '0; r_perr[1] <= '0;
                end
            end
        end
    end

    // work registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            case (i_cmd.op)
                dwpid_pkg::OP_LOAD: begin
                    r_samp[0] <= i_lsamp;
                    r_samp[1] <= i_rsamp;
                end
                dwpid_pkg::OP_PID: begin
                    r_err <= err_c;
                    r_der <= der_c;
                    r_out <= 32'($signed({1'b0, r_sp[w][15:0]}));
                end
                dwpid_pkg::OP_MUL_P: r_prod <= 48'(mul_p);
                dwpid_pkg::OP_MUL_I: begin
                    r_out  <= r_out + 32'(r_prod >>> 12);
                    r_prod <= 48'(mul_p);
                end
                dwpid_pkg::OP_MUL_D: begin
                    r_out  <= r_out + 32'(r_prod >>> 18);
                    r_prod <= 48'(mul_p);
                end
                dwpid_pkg::OP_MAP: begin
                    // last product from the d term folds in first when closed loop
                    r_prod <= 48'(mul_p);
                end
                dwpid_pkg::OP_WID: r_w[w] <= wid_c;
                default: ;
            endcase
        end
    end

    assign o_stat.running = r_running;
    assign o_stat.bal_hit = ((r_bal + 7'd1) >= 7'(BALANCE_PERIOD));
    assign o_stat.clr_hit = ((r_clr + 8'd1) >= 8'(CLEAR_PERIOD));
    assign o_lwidth = r_w[0];
    assign o_rwidth = r_w[1];
    assign o_lfwd   = r_dir[0];
    assign o_rfwd   = r_dir[1];

endmodule

// File: design/dual_wheel_pid_speed_control.sv
// ----------------------------------------------------------------------------
// dual_wheel_pid_speed_control: two-wheel PID speed controller
// Feedforward plus PID per wheel on one shared multiplier, PWM width map.
//
//  channel  dir  signals                      payload
//  s_axis   in   s_axis_tvalid/tready/tdata   samples, targets, directions
//                s_axis_tuser                 kind
//  m_axis   out  m_axis_tvalid/tready/tdata   widths, directions
//  cfg      in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// a running tick takes, per wheel, one pid step, three products and a map
// product on the shared multiplier and a width step, then a finish step; start
// items take a map product and width step per wheel; move, stop and idle ticks
// give no result; one item at a time; a result holds on m_axis until taken
// reset is synchronous active low and restores all register reset values
// ----------------------------------------------------------------------------
module dual_wheel_pid_speed_control #(
    parameter int TICK_MS        = dwpid_pkg::TICK_MS_DEF,
    parameter int MAX_WIDTH      = dwpid_pkg::MAX_WIDTH_DEF,
    parameter int RPS_LIMIT      = dwpid_pkg::RPS_LIMIT_DEF,
    parameter int BALANCE_PERIOD = dwpid_pkg::BALANCE_PERIOD_DEF,
    parameter int CLEAR_PERIOD   = dwpid_pkg::CLEAR_PERIOD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // left_sample, right_sample, left_target, right_target,
    // left_forward_cmd, right_forward_cmd, zero fill
    input  logic [71:0] s_axis_tdata,
    // kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_width, right_width, left_forward, right_forward, zero fill
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    dwpid_pkg::t_cmd  cmd;
    dwpid_pkg::t_stat stat;
    logic             busy, in_fire;
    logic [9:0]       lw, rw;
    logic             lf, rf;

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    dwpid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_kind      (s_axis_tuser),
        .i_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_busy      (busy),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    dwpid_dp #(
        .TICK_MS        (TICK_MS),
        .MAX_WIDTH      (MAX_WIDTH),
        .RPS_LIMIT      (RPS_LIMIT),
        .BALANCE_PERIOD (BALANCE_PERIOD),
        .CLEAR_PERIOD   (CLEAR_PERIOD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_fire  (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (s_axis_tuser),
        .i_lsamp     (s_axis_tdata[15:0]),
        .i_rsamp     (s_axis_tdata[31:16]),
        .i_ltgt      (s_axis_tdata[47:32]),
        .i_rtgt      (s_axis_tdata[63:48]),
        .i_lfwd      (s_axis_tdata[64]),
        .i_rfwd      (s_axis_tdata[65]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_lwidth    (lw),
        .o_rwidth    (rw),
        .o_lfwd      (lf),
        .o_rfwd      (rf)
    );

    assign m_axis_tdata = {2'b00, rf, lf, rw, lw};

endmodule

// File: design/dwpid_checker.sv
// ----------------------------------------------------------------------------
// dwpid_checker: port-level checks
// Watches the stream ports of the speed controller.
// ----------------------------------------------------------------------------
module dwpid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // no new item while a result waits
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // fill bits stay zero
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00) else $error("fill bits set");

    // result taken frees the input side
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready) else $error("input not freed");

endmodule

bind dual_wheel_pid_speed_control dwpid_checker u_dwpid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
